FILE: hdl/assert_macros.svh
// Concurrent assertion helpers; the enclosing module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define HPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hpq assertion failed");

// Check on every rising edge, reset included.
`define HPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("hpq assertion failed");

`endif

FILE: hdl/hpq_pkg.sv
`default_nettype none

package hpq_pkg;

  localparam int unsigned PRIO_W = 32;
  localparam int unsigned VAL_W  = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [VAL_W-1:0]         value;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/hpq_ifs.sv
`default_nettype none

interface hpq_req_if
  import hpq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [VAL_W-1:0]         item_value;
  logic signed [PRIO_W-1:0] item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

interface hpq_rsp_if
  import hpq_pkg::*;
#(
  parameter int unsigned CNT_W = 11
);
  logic                     valid;
  logic                     ready;
  logic [VAL_W-1:0]         removed_value;
  logic [VAL_W-1:0]         head_value;
  logic signed [PRIO_W-1:0] head_priority;
  logic                     queue_empty;
  logic [CNT_W-1:0]         entry_count;
  logic [1:0]               status;

  modport source (output valid, removed_value, head_value, head_priority, queue_empty,
                  entry_count, status, input ready);
  modport sink   (input valid, removed_value, head_value, head_priority, queue_empty,
                  entry_count, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/hpq_mem.sv
`default_nettype none

module hpq_mem
  import hpq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/hpq_ctrl.sv
`default_nettype none

module hpq_ctrl
  import hpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned IDX_W = $clog2(CAPACITY),
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  hpq_req_if.sink               req_i,
  hpq_rsp_if.source             rsp_o,
  output logic                  mem_we_o,
  output logic [IDX_W-1:0]      mem_waddr_o,
  output entry_t                mem_wdata_o,
  output logic [IDX_W-1:0]      mem_raddr_o,
  input  wire entry_t           mem_rdata_i
);

  localparam int unsigned CH_W = IDX_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST_RD,
    ST_DN_LAST,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_PLACE,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  hole_q, hole_d;
  entry_t            moving_q, moving_d;
  entry_t            left_q, left_d;
  entry_t            head_q, head_d;
  logic [VAL_W-1:0]  removed_q, removed_d;
  status_e           status_q, status_d;

  logic                     rsp_valid_q;
  logic [VAL_W-1:0]         rsp_removed_q;
  logic [VAL_W-1:0]         rsp_head_value_q;
  logic signed [PRIO_W-1:0] rsp_head_prio_q;
  logic                     rsp_empty_q;
  logic [CNT_W-1:0]         rsp_count_q;
  status_e                  rsp_status_q;
  logic                     rsp_load;

  logic [IDX_W-1:0] hole_m1;
  logic [IDX_W-1:0] parent_idx;
  logic [IDX_W-1:0] pparent_m1;
  logic [IDX_W-1:0] pparent_idx;
  logic [CH_W-1:0]  count_ext;
  logic [CH_W-1:0]  lchild;
  logic [CH_W-1:0]  rchild;
  logic             right_ok;
  logic [CH_W-1:0]  sel_idx;
  entry_t           sel_entry;
  logic [CH_W-1:0]  sel_lchild;

  assign hole_m1     = hole_q - IDX_W'(1);
  assign parent_idx  = IDX_W'(hole_m1 >> 1);
  assign pparent_m1  = parent_idx - IDX_W'(1);
  assign pparent_idx = IDX_W'(pparent_m1 >> 1);
  assign count_ext   = CH_W'(count_q);
  assign lchild      = {1'b0, hole_q, 1'b1};
  assign rchild      = {1'b0, hole_q, 1'b0} + CH_W'(2);
  assign right_ok    = rchild < count_ext;

  // Right child wins only when strictly smaller than the left one.
  always_comb begin
    if (right_ok && (mem_rdata_i.prio < left_q.prio)) begin
      sel_idx   = rchild;
      sel_entry = mem_rdata_i;
    end else begin
      sel_idx   = lchild;
      sel_entry = left_q;
    end
    sel_lchild = {1'b0, sel_idx[IDX_W-1:0], 1'b1};
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_load    = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hole_d      = hole_q;
    moving_d    = moving_q;
    left_d      = left_q;
    head_d      = head_q;
    removed_d   = removed_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = hole_q;
    mem_wdata_o = moving_q;
    mem_raddr_o = parent_idx;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          removed_d = '0;
          status_d  = STATUS_OK;
          if (req_i.operation == OP_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = ST_FINISH;
            end else begin
              moving_d.prio  = req_i.item_priority;
              moving_d.value = req_i.item_value;
              hole_d         = count_q[IDX_W-1:0];
              count_d        = count_q + CNT_W'(1);
              state_d        = (count_q == '0) ? ST_PLACE : ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = ST_FINISH;
            end else begin
              removed_d = head_q.value;
              count_d   = count_q - CNT_W'(1);
              state_d   = (count_q == CNT_W'(1)) ? ST_FINISH : ST_DN_LAST_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        mem_raddr_o = parent_idx;
        state_d     = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (moving_q.prio < mem_rdata_i.prio) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          hole_d      = parent_idx;
          mem_raddr_o = pparent_idx;
          state_d     = (parent_idx == '0) ? ST_PLACE : ST_UP_CMP;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_DN_LAST_RD: begin
        mem_raddr_o = count_q[IDX_W-1:0];
        state_d     = ST_DN_LAST;
      end
      ST_DN_LAST: begin
        moving_d    = mem_rdata_i;
        hole_d      = '0;
        mem_raddr_o = IDX_W'(1);
        state_d     = (count_q > CNT_W'(1)) ? ST_DN_RDR : ST_PLACE;
      end
      ST_DN_RDR: begin
        left_d      = mem_rdata_i;
        mem_raddr_o = rchild[IDX_W-1:0];
        state_d     = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (sel_entry.prio < moving_q.prio) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = sel_entry;
          if (hole_q == '0) begin
            head_d = sel_entry;
          end
          hole_d      = sel_idx[IDX_W-1:0];
          mem_raddr_o = sel_lchild[IDX_W-1:0];
          state_d     = (sel_lchild < count_ext) ? ST_DN_RDR : ST_PLACE;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        mem_we_o = 1'b1;
        if (hole_q == '0) begin
          head_d = moving_q;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      hole_q    <= hole_d;
      moving_q  <= moving_d;
      left_q    <= left_d;
      head_q    <= head_d;
      removed_q <= removed_d;
      status_q  <= status_d;
      if (rsp_load) begin
        rsp_valid_q      <= 1'b1;
        rsp_removed_q    <= removed_q;
        rsp_head_value_q <= (count_q != '0) ? head_q.value : '0;
        rsp_head_prio_q  <= (count_q != '0) ? head_q.prio : '0;
        rsp_empty_q      <= (count_q == '0);
        rsp_count_q      <= count_q;
        rsp_status_q     <= status_q;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.removed_value = rsp_removed_q;
  assign rsp_o.head_value    = rsp_head_value_q;
  assign rsp_o.head_priority = rsp_head_prio_q;
  assign rsp_o.queue_empty   = rsp_empty_q;
  assign rsp_o.entry_count   = rsp_count_q;
  assign rsp_o.status        = rsp_status_q;

  `include "assert_macros.svh"

  `HPQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `HPQ_ASSERT(a_write_states,
              mem_we_o |-> (state_q == ST_UP_CMP || state_q == ST_DN_CMP || state_q == ST_PLACE))
  `HPQ_ASSERT(a_hole_in_heap,
              (state_q == ST_UP_CMP || state_q == ST_DN_CMP || state_q == ST_PLACE)
              |-> (CNT_W'(hole_q) < count_q))
  `HPQ_ASSERT(a_rsp_after_finish, $rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))

endmodule

`default_nettype wire

FILE: hdl/binary_min_heap_priority_queue_top.sv
// Insert sifts the new entry up (not into an empty queue); remove moves the last entry
// to the root and sifts it down. A reject or removal of the last entry skips the heap
// walk.
// Throughput: one transaction at a time; the next request is taken in the cycle after the
// response loads; stalls delay the load. Two RAM reads per level on the way down.
// Reset (rst_ni, asynchronous, active low) empties the queue; the heap RAM is not cleared.
`default_nettype none

module binary_min_heap_priority_queue_top
  import hpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hpq_req_if.sink   req_i,
  hpq_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  // Heap RAM port: one write, one registered read per cycle. The sequencer
  // keeps the entry being sifted in a register and only writes it once it
  // settles, so a level costs a read going up, two going down, and at most one write-back.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // Sequencer: accept a transaction, walk the heap path, then hold the
  // result in the output register until the sink takes it. The root entry
  // is mirrored in a register, so head fields and removed value need no read.
  hpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Priority and payload share one word per heap slot.
  hpq_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb
  import hpq_pkg::*;
;

  localparam int unsigned HEAP_DEPTH  = 1024;
  localparam int unsigned COUNT_W     = 11;
  // Worst case: ~570 transactions, each with a send gap, its time in the heap and a
  // response stall.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 50;

  // One response transaction as the heap reports it.
  typedef struct packed {
    logic [VAL_W-1:0]         removed_value;
    logic [VAL_W-1:0]         head_value;
    logic signed [PRIO_W-1:0] head_priority;
    logic                     queue_empty;
    logic [COUNT_W-1:0]       entry_count;
    status_e                  status;
  } heap_rsp_t;

  // One row of the directed table; typed rows carry their own answer.
  typedef struct {
    op_e              op;
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    heap_rsp_t         want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hpq_req_if                     req_if ();
  hpq_rsp_if #(.CNT_W(COUNT_W)) rsp_if ();

  binary_min_heap_priority_queue_top #(
    .CAPACITY(HEAP_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow heap: the entries and how many are held.
  entry_t      heap_mem [HEAP_DEPTH];
  int unsigned heap_fill = 0;

  heap_rsp_t   heap_results_due [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned run_cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet_idle = 1'b0;

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    run_cycles++;
    if (run_cycles > CYCLE_LIMIT) begin
      $display("binary_min_heap_priority_queue_top regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %h, want %h", name, got, want));
    end
  endtask

  // Apply one transaction to the shadow heap and return what the block should
  // report. Ties never move an entry; on the way down the right child wins only
  // when strictly lower than the left.
  function automatic heap_rsp_t heap_apply(op_e op, logic [VAL_W-1:0] v,
                                           logic [PRIO_W-1:0] p);
    heap_rsp_t   r;
    int unsigned k;
    int unsigned sel;
    entry_t      tmp;
    r        = '0;
    r.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        k = heap_fill;
        heap_mem[k] = '{prio: p, value: v};
        heap_fill++;
        while (k > 0) begin
          if ($signed(heap_mem[k].prio) < $signed(heap_mem[(k - 1) / 2].prio)) begin
            tmp                    = heap_mem[k];
            heap_mem[k]            = heap_mem[(k - 1) / 2];
            heap_mem[(k - 1) / 2]  = tmp;
            k                      = (k - 1) / 2;
          end else begin
            break;
          end
        end
      end
    end else if (heap_fill == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.removed_value = heap_mem[0].value;
      heap_fill--;
      heap_mem[0] = heap_mem[heap_fill];
      k = 0;
      while (2 * k + 1 < heap_fill) begin
        sel = 2 * k + 1;
        if (sel + 1 < heap_fill &&
            $signed(heap_mem[sel + 1].prio) < $signed(heap_mem[sel].prio)) begin
          sel++;
        end
        if ($signed(heap_mem[sel].prio) < $signed(heap_mem[k].prio)) begin
          tmp           = heap_mem[k];
          heap_mem[k]   = heap_mem[sel];
          heap_mem[sel] = tmp;
          k             = sel;
        end else begin
          break;
        end
      end
    end
    if (heap_fill != 0) begin
      r.head_value    = heap_mem[0].value;
      r.head_priority = heap_mem[0].prio;
    end
    r.queue_empty = (heap_fill == 0);
    r.entry_count = COUNT_W'(heap_fill);
    return r;
  endfunction

  function automatic heap_rsp_t mk_rsp(logic [31:0] removed, logic [31:0] hv,
                                       logic [31:0] hp, bit is_empty, int cnt,
                                       status_e st);
    heap_rsp_t r;
    r.removed_value = removed;
    r.head_value    = hv;
    r.head_priority = hp;
    r.queue_empty   = is_empty;
    r.entry_count   = COUNT_W'(cnt);
    r.status        = st;
    return r;
  endfunction

  task automatic add_row(op_e op, logic [31:0] v, logic [31:0] p, bit typed = 1'b0,
                         heap_rsp_t want = '0);
    stim_row_t row;
    row.op    = op;
    row.value = v;
    row.prio  = p;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Idle length: half the time the shortest, else longer, rarely a long stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 1;
    if (r < 80) return $urandom_range(2, 4);
    if (r < 95) return $urandom_range(5, 10);
    return $urandom_range(15, 30);
  endfunction

  // Mix wide random priorities with a narrow band (many ties) and the extremes.
  function automatic logic [31:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          4:       return 32'h8000_0001;
          default: return 32'h7fff_fffe;
        endcase
      end
      2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request transaction, starting and ending at a rising edge.
  // Record the expected response at the edge of acceptance.
  task automatic send_item(op_e op, logic [31:0] v, logic [31:0] p, bit typed = 1'b0,
                           heap_rsp_t want = '0);
    int        gap;
    heap_rsp_t predicted;
    gap = (quiet_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.item_value    <= v;
    req_if.item_priority <= p;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = heap_apply(op, v, p);
    heap_results_due.push_back(typed ? want : predicted);
  endtask

  // Random traffic in segments: growth runs, drain runs (which overshoot into
  // remove-on-empty) and mixed runs. Remove requests carry junk in the unused
  // fields.
  task automatic run_random(int n);
    int  done;
    int  seg;
    int  len;
    op_e op;
    done = 0;
    while (done < n) begin
      quiet_idle = ($urandom_range(0, 4) == 0);
      seg        = $urandom_range(0, 3);
      len        = $urandom_range(1, 40);
      for (int i = 0; i < len && done < n; i++) begin
        case (seg)
          0:       op = ($urandom_range(0, 9) != 0) ? OP_INSERT : OP_REMOVE;
          1:       op = OP_REMOVE;
          default: op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_REMOVE;
        endcase
        send_item(op, $urandom, pick_priority());
        done++;
      end
    end
  endtask

  // Response side: stall at random, with stretches of steady ready.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!quiet_idle && $urandom_range(0, 9) == 0) begin
        stall_left = idle_len();
      end
    end
  end

  // Compare each accepted response against the oldest expectation.
  always @(posedge clk_i) begin
    heap_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (heap_results_due.size() == 0) begin
        report_mismatch("response transaction with nothing expected");
      end else begin
        want = heap_results_due.pop_front();
        check_field("removed_value", rsp_if.removed_value, want.removed_value);
        check_field("head_value", rsp_if.head_value, want.head_value);
        check_field("head_priority", rsp_if.head_priority, want.head_priority);
        check_field("queue_empty", 32'(rsp_if.queue_empty), 32'(want.queue_empty));
        check_field("entry_count", 32'(rsp_if.entry_count), 32'(want.entry_count));
        check_field("status", 32'(rsp_if.status), 32'(want.status));
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.operation     = OP_INSERT;
    req_if.item_value    = '0;
    req_if.item_priority = '0;
    rsp_if.ready         = 1'b0;

    // Directed table. Typed rows are plain to read off: empty queue, extreme
    // priorities, ties at the root. The rest go through the shadow heap.
    add_row(OP_REMOVE, 32'h0, 32'h0, 1'b1,
            mk_rsp(32'h0, 32'h0, 32'h0, 1'b1, 0, STATUS_EMPTY));
    add_row(OP_INSERT, 32'hffff_ffff, 32'h7fff_ffff, 1'b1,
            mk_rsp(32'h0, 32'hffff_ffff, 32'h7fff_ffff, 1'b0, 1, STATUS_OK));
    add_row(OP_INSERT, 32'h0, 32'h8000_0000, 1'b1,
            mk_rsp(32'h0, 32'h0, 32'h8000_0000, 1'b0, 2, STATUS_OK));
    add_row(OP_INSERT, 32'ha5a5_a5a5, 32'h0, 1'b1,
            mk_rsp(32'h0, 32'h0, 32'h8000_0000, 1'b0, 3, STATUS_OK));
    add_row(OP_INSERT, 32'h1, 32'hffff_ffff, 1'b1,
            mk_rsp(32'h0, 32'h0, 32'h8000_0000, 1'b0, 4, STATUS_OK));
    // Tie with the root: the new entry stays below it.
    add_row(OP_INSERT, 32'h2, 32'h8000_0000, 1'b1,
            mk_rsp(32'h0, 32'h0, 32'h8000_0000, 1'b0, 5, STATUS_OK));
    add_row(OP_REMOVE, 32'h0, 32'h0);
    add_row(OP_REMOVE, 32'hdead_beef, 32'h1234_5678);
    add_row(OP_INSERT, 32'h5a5a_5a5a, 32'h1);
    add_row(OP_INSERT, 32'h3, 32'hffff_ffff);
    add_row(OP_INSERT, 32'h4, 32'hffff_ffff);
    add_row(OP_INSERT, 32'h6, 32'h7fff_ffff);
    repeat (7) add_row(OP_REMOVE, 32'h0, 32'h0);
    // Unused fields all ones on a remove from an empty queue.
    add_row(OP_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
            mk_rsp(32'h0, 32'h0, 32'h0, 1'b1, 0, STATUS_EMPTY));
    add_row(OP_INSERT, 32'h1234_5678, 32'h7fff_ffff, 1'b1,
            mk_rsp(32'h0, 32'h1234_5678, 32'h7fff_ffff, 1'b0, 1, STATUS_OK));
    add_row(OP_REMOVE, 32'h0, 32'h0, 1'b1,
            mk_rsp(32'h1234_5678, 32'h0, 32'h0, 1'b1, 0, STATUS_OK));

    // Hold reset, then release it at a rising edge.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].prio,
                directed_rows[i].typed, directed_rows[i].want);
    end

    run_random(300);
    run_random(250);

    // Release the request side and let every response come back.
    req_if.valid <= 1'b0;
    quiet_idle = 1'b0;
    while (heap_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("binary_min_heap_priority_queue_top regression: pass");
    end else begin
      $display("binary_min_heap_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/hpq_pkg.sv
hdl/hpq_ifs.sv
hdl/hpq_mem.sv
hdl/hpq_ctrl.sv
hdl/binary_min_heap_priority_queue_top.sv
dv/tb.sv
